// ===== rtl/hapd_pkg.sv =====
// Shared types, command codes and the bridge nibble encoder for the H-bridge pulse driver.
// Self-contained; imported by hapd_bridge_store and hbridge_array_pulse_driver.
package hapd_pkg;

    localparam int BOARD_CHIPS  = 6;
    localparam int CHIP_BRIDGES = 6;
    localparam int NUM_REGS     = 3;
    localparam int ROW_W        = BOARD_CHIPS * CHIP_BRIDGES;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [7:0] CMD_LENGTHS = 8'h80;
    localparam logic [7:0] CMD_BRIDGES = 8'h81;
    localparam logic [7:0] CMD_END     = 8'h82;

    localparam logic [3:0] CODE_FWD = 4'b0110;
    localparam logic [3:0] CODE_REV = 4'b1001;

    localparam logic [15:0] LEN_RESET = 16'd500;

    localparam logic [1:0] PH_PAUSE = 2'd0;
    localparam logic [1:0] PH_FWD   = 2'd1;
    localparam logic [1:0] PH_GAP   = 2'd2;
    localparam logic [1:0] PH_REV   = 2'd3;

    localparam logic [1:0] REG_LAST = 2'(NUM_REGS - 1);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_BRIDGES = 2'd1,
        MODE_LENGTHS = 2'd2
    } t_rx_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_EVAL,
        ST_READ,
        ST_FRAME
    } t_state;

    // Data byte for one chip: low nibble is bridge reg_idx*2, high nibble the next one.
    function automatic logic [7:0] chip_byte(input logic [5:0] bits,
                                             input logic [1:0] reg_idx,
                                             input logic [1:0] phase);
        logic [3:0] code;
        logic [2:0] sel;
        logic [7:0] v;
        code = (phase == PH_REV) ? CODE_REV : CODE_FWD;
        sel  = {reg_idx, 1'b0};
        v    = 8'd0;
        if (phase == PH_FWD || phase == PH_REV) begin
            if (bits[sel])        v[3:0] = code;
            if (bits[sel + 3'd1]) v[7:4] = code;
        end
        return v;
    endfunction

endpackage

// ===== rtl/hapd_bridge_store.sv =====
// Bridge selection memory: one row per board, six bits per chip, written one chip lane at a time.
// Depends on hapd_pkg; per-chip valid bits make unwritten chips read as all bridges off.
module hapd_bridge_store
    import hapd_pkg::*;
#(
    parameter int BOARD_COUNT = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [((BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1)-1:0] i_wr_board,
    input  logic [2:0]           i_wr_chip,
    input  logic [5:0]           i_wr_bits,
    input  logic                 i_rd_en,
    input  logic [((BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1)-1:0] i_rd_board,
    output logic [ROW_W-1:0]     o_row
);

    logic [ROW_W-1:0]       r_mem [BOARD_COUNT];
    logic [BOARD_CHIPS-1:0] r_vld [BOARD_COUNT];
    logic [ROW_W-1:0]       r_rd_data;
    logic [BOARD_CHIPS-1:0] r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_board][int'(i_wr_chip) * CHIP_BRIDGES +: CHIP_BRIDGES] <= i_wr_bits;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_board];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BOARD_COUNT; b++) begin
                r_vld[b] <= '0;
            end
            r_rd_vld <= '0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_board][i_wr_chip] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_board];
            end
        end
    end

    // A chip that was never loaded since reset drives all of its bridges off.
    always_comb begin
        for (int c = 0; c < BOARD_CHIPS; c++) begin
            o_row[c * CHIP_BRIDGES +: CHIP_BRIDGES] =
                r_rd_data[c * CHIP_BRIDGES +: CHIP_BRIDGES] &
                {CHIP_BRIDGES{r_rd_vld[c]}};
        end
    end

endmodule

// ===== rtl/hbridge_array_pulse_driver.sv =====
// Flow: an accepted tick or byte goes to EVAL and, if it changes the phase, on to READ and FRAME
// (the eighth length byte first rebuilds the phase bounds in BOUND, then goes to EVAL).
// No new item is taken until the block is back in IDLE. A phase change costs one memory read
// and three frames per board, and output back-pressure can stall FRAME.
// Reset (synchronous, active low): lengths 500 each, bridges off, pause phase, position 0;
// no clearing pass, the block is ready to accept an item as soon as reset is released.
module hbridge_array_pulse_driver
    import hapd_pkg::*;
#(
    parameter int BOARD_COUNT = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // rx_byte [7:0]
    input  logic [0:0]             s_axis_tuser,  // op [0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // board [0], reg_index [2:1], chip0_byte [10:3], chip1_byte [18:11], chip2_byte [26:19],
    // chip3_byte [34:27], chip4_byte [42:35], chip5_byte [50:43], pulse_phase [52:51]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast   // last
);

    localparam int BW = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
    localparam int CW = $clog2(BOARD_COUNT + 1);

    t_state              r_state, n_state;
    t_rx_mode            r_mode;
    logic [2:0]          r_rx_count;
    logic [CW-1:0]       r_ld_board;
    logic [2:0]          r_ld_chip;
    logic [15:0]         r_pend [4];
    logic [15:0]         r_act [4];
    logic [17:0]         r_bound [4];
    logic [1:0]          r_step;
    logic [1:0]          r_phase;
    logic [17:0]         r_pos;
    logic [BW-1:0]       r_fr_board;
    logic [1:0]          r_fr_reg;
    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                r_out_last;

    logic                acc;
    logic                is_tick;
    logic [7:0]          rx_byte;
    logic                latch_now;
    logic                bridge_wr;
    logic                rd_en;
    logic                out_load;
    logic                found;
    logic [1:0]          target;
    logic [18:0]         pos_inc;
    logic [ROW_W-1:0]    row;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic                n_out_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid & s_axis_tready;
    assign is_tick       = s_axis_tuser[0];
    assign rx_byte       = s_axis_tdata;
    assign latch_now     = (r_mode == MODE_LENGTHS) && (r_rx_count == 3'd7);
    assign bridge_wr     = acc && !is_tick && (r_mode == MODE_BRIDGES) &&
                           (rx_byte != CMD_END) && (r_ld_board < CW'(BOARD_COUNT));
    assign pos_inc       = {1'b0, r_pos} + 19'd1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    hapd_bridge_store #(
        .BOARD_COUNT (BOARD_COUNT)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (bridge_wr),
        .i_wr_board (r_ld_board[BW-1:0]),
        .i_wr_chip  (r_ld_chip),
        .i_wr_bits  (rx_byte[5:0]),
        .i_rd_en    (rd_en),
        .i_rd_board (r_fr_board),
        .o_row      (row)
    );

    // Phase lookup against the cumulative bounds; the last bound is the period.
    always_comb begin
        found  = 1'b1;
        target = PH_PAUSE;
        if (r_bound[3] == 18'd0) begin
            found = 1'b0;
        end else if (r_pos < r_bound[0]) begin
            target = PH_FWD;
        end else if (r_pos < r_bound[1]) begin
            target = PH_GAP;
        end else if (r_pos < r_bound[2]) begin
            target = PH_REV;
        end else if (r_pos >= r_bound[3]) begin
            found = 1'b0;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[0]   = r_fr_board[0];
        n_out_data[2:1] = r_fr_reg;
        for (int c = 0; c < BOARD_CHIPS; c++) begin
            n_out_data[3 + c * 8 +: 8] =
                chip_byte(row[c * CHIP_BRIDGES +: CHIP_BRIDGES], r_fr_reg, r_phase);
        end
        n_out_data[52:51] = r_phase;
        n_out_last = (r_fr_reg == REG_LAST) && (r_fr_board == BW'(BOARD_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_state = (!is_tick && latch_now) ? ST_BOUND : ST_EVAL;
                end
            end
            ST_BOUND: begin
                if (r_step == 2'd3) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = (found && target != r_phase) ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                rd_en   = 1'b1;
                n_state = ST_FRAME;
            end
            ST_FRAME: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    if (r_fr_reg == REG_LAST) begin
                        n_state = (r_fr_board == BW'(BOARD_COUNT - 1)) ? ST_IDLE : ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_rx_count  <= '0;
            r_ld_board  <= '0;
            r_ld_chip   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pend[i] <= '0;
                r_act[i]  <= LEN_RESET;
            end
            r_bound[0]  <= 18'(LEN_RESET);
            r_bound[1]  <= 18'(LEN_RESET) * 18'd2;
            r_bound[2]  <= 18'(LEN_RESET) * 18'd3;
            r_bound[3]  <= 18'(LEN_RESET) * 18'd4;
            r_step      <= '0;
            r_phase     <= PH_PAUSE;
            r_pos       <= '0;
            r_fr_board  <= '0;
            r_fr_reg    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (is_tick) begin
                    if (r_bound[3] != 18'd0) begin
                        r_pos <= (pos_inc >= {1'b0, r_bound[3]}) ? 18'd0 : pos_inc[17:0];
                    end
                end else begin
                    case (r_mode)
                        MODE_LENGTHS: begin
                            if (r_rx_count[0]) begin
                                r_pend[r_rx_count[2:1]][15:8] <= rx_byte;
                            end else begin
                                r_pend[r_rx_count[2:1]][7:0] <= rx_byte;
                            end
                            if (latch_now) begin
                                // The last byte is the high half of the pause length.
                                r_act[0]   <= r_pend[0];
                                r_act[1]   <= r_pend[1];
                                r_act[2]   <= r_pend[2];
                                r_act[3]   <= {rx_byte, r_pend[3][7:0]};
                                r_bound[0] <= {2'b00, r_pend[0]};
                                r_step     <= 2'd1;
                                r_mode     <= MODE_IDLE;
                            end
                            r_rx_count <= r_rx_count + 3'd1;
                        end
                        MODE_BRIDGES: begin
                            if (rx_byte == CMD_END) begin
                                r_mode <= MODE_IDLE;
                            end else if (bridge_wr) begin
                                if (r_ld_chip == 3'(BOARD_CHIPS - 1)) begin
                                    r_ld_chip  <= '0;
                                    r_ld_board <= r_ld_board + CW'(1);
                                end else begin
                                    r_ld_chip <= r_ld_chip + 3'd1;
                                end
                            end
                        end
                        default: begin
                            r_rx_count <= '0;
                            r_ld_board <= '0;
                            r_ld_chip  <= '0;
                            if (rx_byte == CMD_LENGTHS) begin
                                r_mode <= MODE_LENGTHS;
                                for (int i = 0; i < 4; i++) begin
                                    r_pend[i] <= '0;
                                end
                            end else if (rx_byte == CMD_BRIDGES) begin
                                r_mode <= MODE_BRIDGES;
                            end else begin
                                r_mode <= MODE_IDLE;
                            end
                        end
                    endcase
                end
            end

            // One cumulative bound per cycle after new lengths are latched.
            if (r_state == ST_BOUND) begin
                case (r_step)
                    2'd1:    r_bound[1] <= r_bound[0] + {2'b00, r_act[1]};
                    2'd2:    r_bound[2] <= r_bound[1] + {2'b00, r_act[2]};
                    2'd3:    r_bound[3] <= r_bound[2] + {2'b00, r_act[3]};
                    default: r_bound[0] <= r_bound[0];
                endcase
                r_step <= r_step + 2'd1;
            end

            if (r_state == ST_EVAL && n_state == ST_READ) begin
                r_phase    <= target;
                r_fr_board <= '0;
                r_fr_reg   <= '0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
                r_out_last  <= n_out_last;
                if (r_fr_reg == REG_LAST) begin
                    r_fr_reg   <= '0;
                    r_fr_board <= r_fr_board + BW'(1);
                end else begin
                    r_fr_reg <= r_fr_reg + 2'd1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
